// File: rtl/core/eiec_pkg.sv
// Shared types and constants for the external interrupt edge controller.
package eiec_pkg;

  // Line and port counts
  localparam int unsigned NUM_LINES   = 16;
  localparam int unsigned NUM_PORTS   = 7;
  localparam int unsigned PORT_INPUTS = 7;
  localparam int unsigned LINE_W      = 16;
  localparam int unsigned CODE_W      = 4;
  localparam int unsigned PORT_SEL_W  = $clog2(PORT_INPUTS);
  localparam int unsigned MAP_W       = 64;
  localparam int unsigned IRQ_W       = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_PORT_MAP  = 2'd0,
    CFG_INTERRUPT_MASK = 2'd1,
    CFG_RISING_ENABLE  = 2'd2,
    CFG_FALLING_ENABLE = 2'd3
  } cfg_index_t;

  // Input word
  typedef struct packed {
    logic [LINE_W-1:0] port_a_levels;
    logic [LINE_W-1:0] port_b_levels;
    logic [LINE_W-1:0] port_c_levels;
    logic [LINE_W-1:0] port_d_levels;
    logic [LINE_W-1:0] port_e_levels;
    logic [LINE_W-1:0] port_f_levels;
    logic [LINE_W-1:0] port_g_levels;
    logic [LINE_W-1:0] clear_mask;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [LINE_W-1:0] pending_lines;
    logic [LINE_W-1:0] edge_events;
    logic [IRQ_W-1:0]  irq_requests;
  } out_word_t;

  // Edge enables handed to the detector
  typedef struct packed {
    logic [LINE_W-1:0] rising;
    logic [LINE_W-1:0] falling;
  } edge_cfg_t;

  // Mask of the lines that exist
  localparam logic [LINE_W-1:0] LINE_MASK = LINE_W'((32'd1 << NUM_LINES) - 32'd1);

endpackage

// File: rtl/core/eiec_edge_detect.sv
// Per-line port selection and edge detection for the interrupt controller.
module eiec_edge_detect (
  input  eiec_pkg::in_word_t                 in_word,
  input  logic [eiec_pkg::MAP_W-1:0]         line_port_map,
  input  eiec_pkg::edge_cfg_t                edge_cfg,
  input  logic [eiec_pkg::LINE_W-1:0]        prev_levels,
  output logic [eiec_pkg::LINE_W-1:0]        now_levels,
  output logic [eiec_pkg::LINE_W-1:0]        events
);

  logic [eiec_pkg::PORT_INPUTS-1:0][eiec_pkg::LINE_W-1:0] ports;

  // Port levels by port code
  assign ports[0] = in_word.port_a_levels;
  assign ports[1] = in_word.port_b_levels;
  assign ports[2] = in_word.port_c_levels;
  assign ports[3] = in_word.port_d_levels;
  assign ports[4] = in_word.port_e_levels;
  assign ports[5] = in_word.port_f_levels;
  assign ports[6] = in_word.port_g_levels;

  // Line i reads pin i of its selected port; unused codes read low
  always_comb begin
    logic [eiec_pkg::CODE_W-1:0] code;
    now_levels = '0;
    for (int i = 0; i < eiec_pkg::LINE_W; i++) begin
      code = line_port_map[eiec_pkg::CODE_W*i +: eiec_pkg::CODE_W];
      if ((i < eiec_pkg::NUM_LINES) &&
          (32'(code) < eiec_pkg::NUM_PORTS) &&
          (32'(code) < eiec_pkg::PORT_INPUTS)) begin
        now_levels[i] = ports[code[eiec_pkg::PORT_SEL_W-1:0]][i];
      end
    end
  end

  // Enabled rising or falling edges against last word's levels
  assign events = ((now_levels & ~prev_levels & edge_cfg.rising) |
                   (~now_levels & prev_levels & edge_cfg.falling)) & eiec_pkg::LINE_MASK;

endmodule

// File: rtl/core/external_interrupt_edge_controller.sv
// The result word for an accepted input word is registered and valid in the cycle after acceptance.
// Throughput: one word per cycle unless the output is stalled; the result register frees up as it is taken.
// Pending bits and previous levels update in the cycle a word is accepted.
// Synchronous active-low reset clears config, pending bits, previous levels
// and the result valid flag.
module external_interrupt_edge_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  eiec_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output eiec_pkg::out_word_t                out_data,
  input  logic                               cfg_wr_en,
  input  logic [eiec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [eiec_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [eiec_pkg::MAP_W-1:0]  map_r;
  logic [eiec_pkg::LINE_W-1:0] mask_r;
  eiec_pkg::edge_cfg_t         edge_cfg_r;
  logic [eiec_pkg::LINE_W-1:0] prev_r, prev_nxt;
  logic [eiec_pkg::LINE_W-1:0] pend_r, pend_nxt;
  logic                        out_valid_r, out_valid_nxt;
  eiec_pkg::out_word_t         out_r, out_nxt;
  logic [eiec_pkg::LINE_W-1:0] events;
  logic                        accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r      <= '0;
      mask_r     <= '0;
      edge_cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (eiec_pkg::cfg_index_t'(cfg_index))
        eiec_pkg::CFG_LINE_PORT_MAP:  map_r <= cfg_data[eiec_pkg::MAP_W-1:0];
        eiec_pkg::CFG_INTERRUPT_MASK: mask_r <= cfg_data[eiec_pkg::LINE_W-1:0];
        eiec_pkg::CFG_RISING_ENABLE:  edge_cfg_r.rising <= cfg_data[eiec_pkg::LINE_W-1:0];
        eiec_pkg::CFG_FALLING_ENABLE: edge_cfg_r.falling <= cfg_data[eiec_pkg::LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a word whenever the result register is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  eiec_edge_detect u_edge (
    .in_word       (in_data),
    .line_port_map (map_r),
    .edge_cfg      (edge_cfg_r),
    .prev_levels   (prev_r),
    .now_levels    (prev_nxt),
    .events        (events)
  );

  // Clear first, then set from unmasked events; build the result word
  always_comb begin
    pend_nxt = ((pend_r & ~in_data.clear_mask) | (events & mask_r)) & eiec_pkg::LINE_MASK;
    out_nxt.pending_lines   = pend_nxt;
    out_nxt.edge_events     = events;
    out_nxt.irq_requests    = {|pend_nxt[15:10], |pend_nxt[9:5], pend_nxt[4:0]};
    out_valid_nxt = accept || (out_valid_r && !out_ready);
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        prev_r <= prev_nxt;
        pend_r <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/eiec_checker.sv
// Port-level checker for the external interrupt edge controller, with its bind.
module eiec_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input eiec_pkg::out_word_t out_data
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input stalls only behind a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // Single irq bits mirror pending lines 0-4
  a_irq_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.irq_requests[4:0] == out_data.pending_lines[4:0])
    else $error("single irq bits disagree with pending lines");

  // Grouped irq bits are the OR of their lines
  a_irq_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.irq_requests[5] == (|out_data.pending_lines[9:5])) &&
                  (out_data.irq_requests[6] == (|out_data.pending_lines[15:10])))
    else $error("grouped irq bits disagree with pending lines");

endmodule

bind external_interrupt_edge_controller eiec_checker u_eiec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
